@@ rtl/dmtc_pkg.sv @@
// dmtc_pkg: shared constants and types for the direct-mapped cache tag check
// no dependencies; imported by the tag check top level and its checker

package dmtc_pkg;

  // cache geometry
  localparam int unsigned LINES      = 16;
  localparam int unsigned IDX_W      = $clog2(LINES);
  localparam int unsigned ADDR_BITS  = 22;
  localparam int unsigned WORD_BYTES = 4;
  localparam int unsigned WORD_SHIFT = $clog2(WORD_BYTES);
  localparam int unsigned BLK_W      = ADDR_BITS - WORD_SHIFT;
  localparam int unsigned TAG_BITS   = 16;

  // block size register
  localparam int unsigned CFG_W = 3;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [CFG_W-1:0]     cfg_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [BLK_W-1:0]     blk_t;

  localparam cfg_t BLOCK_LOG2_RST = cfg_t'(1);

  // request kinds
  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_INVAL  = 1'b1;

endpackage

@@ rtl/direct_mapped_cache_tag_check.sv @@
// direct_mapped_cache_tag_check: direct-mapped tag store with hit/miss report
// depends on dmtc_pkg
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word per request:
//   req_type_i selects an access lookup or an invalidate of all lines, and
//   address_i is the byte address of an access. The output channel
//   (out_valid_o/out_ready_i) returns one word per request, hit_o, in
//   request order; an invalidate always returns 0.
//   cfg_we_i writes cfg_wdata_i into the block size register (log2 words
//   per block); write it only while no request is in flight.
//   out_valid_o rises once an accepted request has passed the lookup stage
//   and entered the output register. Throughput is one request per cycle
//   while the receiver does not stall: the tag memory is read at acceptance
//   and written back as the request leaves the lookup stage, and a miss to the
//   same line in the next request is forwarded around the memory.
//   Reset clears all valid bits (no clearing pass, flip-flops per line) and
//   sets the block size register to 2 words. Tags are not reset.
//   When the receiver stalls, the result holds in the output register, the
//   following request waits in the lookup stage, and in_ready_o drops.

module direct_mapped_cache_tag_check (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  dmtc_pkg::cfg_t cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           req_type_i,
  input  dmtc_pkg::addr_t address_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           hit_o
);
  import dmtc_pkg::*;

  cfg_t             block_log2_q;
  logic [LINES-1:0] valid_q;
  tag_t             tag_mem [LINES];
  tag_t             rd_tag_q;

  logic s1_vld_q;
  logic s1_type_q;
  idx_t s1_idx_q;
  tag_t s1_tag_q;
  logic fwd_q;
  tag_t fwd_tag_q;

  logic out_vld_q;
  logic hit_q;

  logic in_accept;
  logic s1_done;
  logic s1_hit;
  logic s1_fill;
  tag_t s1_stored;
  blk_t in_blk;
  idx_t in_idx;
  tag_t in_tag;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_log2_q <= BLOCK_LOG2_RST;
    end else if (cfg_we_i) begin
      block_log2_q <= cfg_wdata_i;
    end
  end

  // address split into line index and tag
  assign in_blk = blk_t'(address_i >> WORD_SHIFT) >> block_log2_q;
  assign in_idx = in_blk[IDX_W-1:0];
  assign in_tag = tag_t'(in_blk >> IDX_W);

  // handshake
  assign s1_done    = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_done;
  assign in_accept  = in_valid_i && in_ready_o;

  // lookup stage compare, with forwarding from the previous fill
  assign s1_stored = fwd_q ? fwd_tag_q : rd_tag_q;
  assign s1_hit    = (s1_type_q == REQ_ACCESS) && valid_q[s1_idx_q] &&
                     (s1_stored == s1_tag_q);
  assign s1_fill   = s1_done && (s1_type_q == REQ_ACCESS) && !s1_hit;

  // tag memory: synchronous read at acceptance, write on fill
  always_ff @(posedge clk_i) begin
    if (s1_fill) begin
      tag_mem[s1_idx_q] <= s1_tag_q;
    end
    if (in_accept) begin
      rd_tag_q <= tag_mem[in_idx];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (s1_done && (s1_type_q == REQ_INVAL)) begin
      valid_q <= '0;
    end else if (s1_fill) begin
      valid_q[s1_idx_q] <= 1'b1;
    end
  end

  // lookup stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_accept) begin
      s1_vld_q <= 1'b1;
    end else if (s1_done) begin
      s1_vld_q <= 1'b0;
    end
  end

  // lookup stage payload and forward capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_type_q <= req_type_i;
      s1_idx_q  <= in_idx;
      s1_tag_q  <= in_tag;
      fwd_q     <= s1_fill && (s1_idx_q == in_idx);
      fwd_tag_q <= s1_tag_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_done) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_done) begin
      hit_q <= s1_hit;
    end
  end

  assign out_valid_o = out_vld_q;
  assign hit_o       = hit_q;

endmodule

@@ rtl/dmtc_checker.sv @@
// dmtc_checker: port-level assertions for the cache tag check, bound to the top
// depends on dmtc_pkg and direct_mapped_cache_tag_check

module dmtc_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            cfg_we_i,
  input dmtc_pkg::cfg_t  cfg_wdata_i,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            req_type_i,
  input dmtc_pkg::addr_t address_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic            hit_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o))
    else $error("result word changed while stalled");

  // the input only backs up behind a full, stalled output
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back pressure");

  // an accepted word reaches the output register after the lookup stage
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 out_valid_o)
    else $error("no result two cycles after acceptance");

  // an invalidate into an empty, ready pipe returns a miss from the output register
  a_inval_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == dmtc_pkg::REQ_INVAL) &&
     !out_valid_o && out_ready_i) ##1 (!out_valid_o || out_ready_i)
    |=> (out_valid_o && !hit_o))
    else $error("invalidate returned a hit");

endmodule

bind direct_mapped_cache_tag_check dmtc_checker u_dmtc_checker (.*);
